FILE: sv/tsq_pkg.sv
package tsq_pkg;

  localparam int DATA_W  = 32;
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = 6;
  localparam int CNT_W   = 7;
  localparam int ROOM_W  = 8;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  localparam logic [MODE_W-1:0] MODE_ENTER = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LEAVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [STAT_W-1:0] status;
    logic [ROOM_W-1:0] free_room;
    logic              is_empty;
    logic              is_full;
  } rsp_t;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(DEPTH)) begin
      r = CNT_W'(DEPTH);
    end
    return r;
  endfunction

endpackage

FILE: sv/two_stack_queue_core.sv
// Flow: a request is captured in IDLE and run in EXEC. Enter, clear, unused-mode,
// refused and empty-queue requests then go to FIN; leave, front and rear that find
// data pass through RD first. Requests are taken one at a time; a stack reversal (REV)
// moves entries with one memory read and one write per cycle, then returns to EXEC.
// Reset: both counts clear and capacity returns to 64; memory contents stay unknown and
// are never read before written, so there is no clearing pass.
module two_stack_queue_core
  import tsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_REV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [DATA_W-1:0] enter_mem [DEPTH];
  logic [DATA_W-1:0] leave_mem [DEPTH];

  logic [2:0]        state, state_next;
  logic [MODE_W-1:0] mode_r;
  logic [DATA_W-1:0] data_r;
  logic [CNT_W-1:0]  ec, ec_next, lc, lc_next, cap;
  logic [CNT_W-1:0]  ec_m1, lc_m1;
  logic              rev_to_leave, rev_next;
  logic              pend, pend_next;
  logic              rd_leave, rd_leave_next;
  logic [DATA_W-1:0] res_data, res_data_next;
  logic [STAT_W-1:0] res_status, res_status_next;

  logic              e_we, e_re, l_we, l_re;
  logic [ADDR_W-1:0] e_wa, e_ra, l_wa, l_ra;
  logic [DATA_W-1:0] e_wd, l_wd, e_q, l_q;

  logic [ROOM_W-1:0] room;
  logic              rsp_load;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign ec_m1     = ec - CNT_W'(1);
  assign lc_m1     = lc - CNT_W'(1);
  assign rsp_load  = (state == S_FIN) && (!rsp_valid || !rsp_stall);
  assign room      = (ROOM_W'(cap) - ROOM_W'(ec)) + ((lc == '0) ? ROOM_W'(cap) : '0);

  always_comb begin
    state_next      = state;
    ec_next         = ec;
    lc_next         = lc;
    rev_next        = rev_to_leave;
    pend_next       = pend;
    rd_leave_next   = rd_leave;
    res_data_next   = res_data;
    res_status_next = res_status;
    e_we = 1'b0;  e_wa = '0;  e_wd = '0;  e_re = 1'b0;  e_ra = '0;
    l_we = 1'b0;  l_wa = '0;  l_wd = '0;  l_re = 1'b0;  l_ra = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_data_next   = '0;
        res_status_next = ST_OK;
        state_next      = S_FIN;
        unique case (mode_r) inside
          MODE_ENTER: begin
            if (ec >= cap) begin
              if (lc != '0) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                rev_next   = 1'b1;
                pend_next  = 1'b0;
                state_next = S_REV;
              end
            end else begin
              e_we    = 1'b1;
              e_wa    = ec[ADDR_W-1:0];
              e_wd    = data_r;
              ec_next = ec + CNT_W'(1);
            end
          end
          MODE_LEAVE, MODE_FRONT: begin
            if (ec == '0 && lc == '0) begin
              res_status_next = ST_EMPTY;
            end else if (lc == '0) begin
              rev_next   = 1'b1;
              pend_next  = 1'b0;
              state_next = S_REV;
            end else begin
              l_re          = 1'b1;
              l_ra          = lc_m1[ADDR_W-1:0];
              rd_leave_next = 1'b1;
              state_next    = S_RD;
              if (mode_r == MODE_LEAVE) begin
                lc_next = lc_m1;
              end
            end
          end
          MODE_REAR: begin
            if (ec == '0 && lc == '0) begin
              res_status_next = ST_EMPTY;
            end else if (ec == '0) begin
              rev_next   = 1'b0;
              pend_next  = 1'b0;
              state_next = S_REV;
            end else begin
              e_re          = 1'b1;
              e_ra          = ec_m1[ADDR_W-1:0];
              rd_leave_next = 1'b0;
              state_next    = S_RD;
            end
          end
          MODE_CLEAR: begin
            ec_next = '0;
            lc_next = '0;
          end
          default: ;
        endcase
      end
      S_REV: begin
        if (rev_to_leave) begin
          if (pend) begin
            l_we    = 1'b1;
            l_wa    = lc[ADDR_W-1:0];
            l_wd    = e_q;
            lc_next = lc + CNT_W'(1);
          end
          if (ec != '0) begin
            e_re      = 1'b1;
            e_ra      = ec_m1[ADDR_W-1:0];
            ec_next   = ec_m1;
            pend_next = 1'b1;
          end else begin
            pend_next  = 1'b0;
            state_next = S_EXEC;
          end
        end else begin
          if (pend) begin
            e_we    = 1'b1;
            e_wa    = ec[ADDR_W-1:0];
            e_wd    = l_q;
            ec_next = ec + CNT_W'(1);
          end
          if (lc != '0) begin
            l_re      = 1'b1;
            l_ra      = lc_m1[ADDR_W-1:0];
            lc_next   = lc_m1;
            pend_next = 1'b1;
          end else begin
            pend_next  = 1'b0;
            state_next = S_EXEC;
          end
        end
      end
      S_RD: begin
        res_data_next = rd_leave ? l_q : e_q;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      enter_mem[e_wa] <= e_wd;
    end
    if (e_re) begin
      e_q <= enter_mem[e_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      leave_mem[l_wa] <= l_wd;
    end
    if (l_re) begin
      l_q <= leave_mem[l_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ec        <= '0;
      lc        <= '0;
      cap       <= CAP_RESET;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      ec    <= ec_next;
      lc    <= lc_next;
      pend  <= pend_next;
      if (cfg_valid && cfg_ready && ec == '0 && lc == '0) begin
        cap <= clamp_cap(cfg_data);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      mode_r <= req.mode;
      data_r <= req.data_in;
    end
    rev_to_leave <= rev_next;
    rd_leave     <= rd_leave_next;
    res_data     <= res_data_next;
    res_status   <= res_status_next;
    if (rsp_load) begin
      rsp.data_out  <= res_data;
      rsp.status    <= res_status;
      rsp.free_room <= room;
      rsp.is_empty  <= (ec == '0) && (lc == '0);
      rsp.is_full   <= (room == '0);
    end
  end

`ifndef SYNTHESIS
  a_counts_in_cap: assert property (@(posedge clk) disable iff (rst)
    (ec <= cap) && (lc <= cap))
    else $error("stack count above capacity");

  a_rev_drains_src: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && ($past(state) == S_REV) |->
      ((rev_to_leave && ec == '0) || (!rev_to_leave && lc == '0)))
    else $error("reversal ended with source stack not empty");

  a_rev_dst_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV) && $past(state_next == S_REV) && $past(state == S_EXEC) |->
      ((rev_to_leave && lc == '0) || (!rev_to_leave && ec == '0)))
    else $error("reversal started onto a non-empty stack");

  a_fail_zero_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> ((res_status == ST_OK) || (res_data == '0)))
    else $error("failed request carries data");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tsq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  logic [DATA_W-1:0] enter_mem [DEPTH];
  logic [DATA_W-1:0] leave_mem [DEPTH];
  int                enter_n = 0;
  int                leave_n = 0;
  int                capacity = DEPTH;
  rsp_t              expected_q [$];

  int errors = 0;
  int cycles = 0;
  int gap_pct = 30;
  int stall_pct = 30;
  int hold_left = 0;

  two_stack_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int idle_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic move_enter_to_leave();
    while (enter_n > 0 && leave_n < DEPTH) begin
      enter_n--;
      leave_mem[leave_n] = enter_mem[enter_n];
      leave_n++;
    end
  endtask

  task automatic predict_result(input req_t item);
    rsp_t r;
    int   room;
    r = '0;
    r.status = ST_OK;
    case (item.mode)
      MODE_ENTER: begin
        if (enter_n >= capacity && leave_n == 0) move_enter_to_leave();
        if (enter_n < capacity) begin
          enter_mem[enter_n] = item.data_in;
          enter_n++;
        end else begin
          r.status = ST_OVERFLOW;
        end
      end
      MODE_LEAVE, MODE_FRONT: begin
        if (leave_n == 0) move_enter_to_leave();
        if (leave_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = leave_mem[leave_n-1];
          if (item.mode == MODE_LEAVE) leave_n--;
        end
      end
      MODE_REAR: begin
        if (enter_n == 0) begin
          while (leave_n > 0) begin
            leave_n--;
            enter_mem[enter_n] = leave_mem[leave_n];
            enter_n++;
          end
        end
        if (enter_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = enter_mem[enter_n-1];
        end
      end
      MODE_CLEAR: begin
        enter_n = 0;
        leave_n = 0;
      end
      default: ;
    endcase
    room = ((enter_n < capacity) ? capacity - enter_n : 0) + ((leave_n == 0) ? capacity : 0);
    r.free_room = ROOM_W'(room);
    r.is_empty = (enter_n == 0 && leave_n == 0);
    r.is_full = (room == 0);
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", rsp.data_out, '0);
      end else begin
        want = expected_q.pop_front();
        if (rsp.data_out !== want.data_out)
          report_mismatch("data_out", rsp.data_out, want.data_out);
        if (rsp.status !== want.status)
          report_mismatch("status", DATA_W'(rsp.status), DATA_W'(want.status));
        if (rsp.free_room !== want.free_room)
          report_mismatch("free_room", DATA_W'(rsp.free_room), DATA_W'(want.free_room));
        if (rsp.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(rsp.is_empty), DATA_W'(want.is_empty));
        if (rsp.is_full !== want.is_full)
          report_mismatch("is_full", DATA_W'(rsp.is_full), DATA_W'(want.is_full));
      end
    end
  end

  initial begin : drive_result_stall
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        rsp_stall = 1'b1;
        stall_left = idle_length() - 1;
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] word);
    req_t item;
    int   n;
    item.mode = mode;
    item.data_in = word;
    @(negedge clk);
    req_valid = 1'b1;
    req = item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_result(item);
    if ($urandom_range(0, 99) < gap_pct) begin
      n = idle_length();
      @(negedge clk);
      req_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (enter_n == 0 && leave_n == 0)
      capacity = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : int'(value));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [MODE_W-1:0] pick_mode(input int enter_pct);
    int r;
    if ($urandom_range(0, 99) < enter_pct) return MODE_ENTER;
    r = $urandom_range(0, 99);
    if (r < 50) return MODE_LEAVE;
    if (r < 70) return MODE_FRONT;
    if (r < 90) return MODE_REAR;
    if (r < 94) return MODE_CLEAR;
    return MODE_W'(MODE_CLEAR + $urandom_range(1, 3));
  endfunction

  task automatic run_random(input int count, input int enter_pct);
    for (int i = 0; i < count; i++) send_request(pick_mode(enter_pct), $urandom);
  endtask

  task automatic test_empty_queue();
    send_request(MODE_LEAVE, 32'h1234_5678);
    send_request(MODE_FRONT, '0);
    send_request(MODE_REAR, '1);
    for (int m = MODE_CLEAR + 1; m < (1 << MODE_W); m++) send_request(MODE_W'(m), '1);
    send_request(MODE_CLEAR, '0);
  endtask

  task automatic test_small_capacity();
    write_capacity('0);
    send_request(MODE_ENTER, '0);
    send_request(MODE_ENTER, '1);
    send_request(MODE_ENTER, 32'hA5A5_A5A5);
    send_request(MODE_REAR, '0);
    send_request(MODE_FRONT, '0);
    send_request(MODE_LEAVE, '0);
    send_request(MODE_REAR, '0);
    send_request(MODE_LEAVE, '0);
    send_request(MODE_LEAVE, '0);
    send_request(MODE_ENTER, 32'h5A5A_5A5A);
    send_request(MODE_FRONT, '0);
    send_request(MODE_REAR, '0);
    send_request(MODE_CLEAR, '0);
  endtask

  task automatic test_capacity_locked();
    send_request(MODE_ENTER, 32'h8000_0001);
    write_capacity(CNT_W'(2));
    send_request(MODE_ENTER, 32'h7FFF_FFFE);
    send_request(MODE_ENTER, 32'hDEAD_BEEF);
    send_request(MODE_CLEAR, '0);
    write_capacity('1);
  endtask

  task automatic test_random_traffic();
    gap_pct = 0;
    stall_pct = 0;
    send_request(MODE_CLEAR, '0);
    write_capacity(CNT_W'(DEPTH));
    run_random(140, 85);
    gap_pct = 30;
    stall_pct = 30;
    send_request(MODE_CLEAR, '0);
    write_capacity(CNT_W'(1));
    run_random(60, 50);
    send_request(MODE_CLEAR, '0);
    write_capacity(CNT_W'(2));
    run_random(60, 55);
    send_request(MODE_CLEAR, '0);
    write_capacity(CNT_W'($urandom_range(3, DEPTH - 1)));
    run_random(60, 60);
    gap_pct = 15;
    stall_pct = 50;
    send_request(MODE_CLEAR, '0);
    write_capacity(CNT_W'(100));
    run_random(60, 60);
  endtask

  task automatic test_backpressure();
    wait_idle();
    gap_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = 300;
    run_random(40, 70);
    gap_pct = 30;
    stall_pct = 30;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_queue();
    test_small_capacity();
    test_capacity_locked();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tsq_pkg.sv
sv/two_stack_queue_core.sv
dv/testbench.sv
